// ===== design/bfca_pkg.sv =====
// -----------------------------------------------------------------------------
// Best-fit allocator package
// Shared constants and command codes for the best-fit coalescing allocator.
// -----------------------------------------------------------------------------
`default_nettype none

package bfca_pkg;

  // Default pool size in granules.
  localparam int unsigned PoolGranulesDef = 512;
  // Bytes per granule, as a shift.
  localparam int unsigned GranuleShift = 5;
  // Width of the working offset arithmetic.
  localparam int unsigned XW = 14;
  // Width of an insertion stamp.
  localparam int unsigned SW = 32;

  // Command codes.
  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_REPORT  = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_APPLY = 4'b0100,
    S_RESP  = 4'b1000
  } state_e;

endpackage

`default_nettype wire

// ===== design/bfca_cell.sv =====
// -----------------------------------------------------------------------------
// Block table cell
// Holds one granule entry of the block table and hands it to its neighbour
// whenever the ring advances.
// -----------------------------------------------------------------------------
`default_nettype none

module bfca_cell #(
  parameter int unsigned W = 44
) (
  input  wire logic         clk_i,
  input  wire logic         shift_i,
  input  wire logic [W-1:0] d_i,
  output logic      [W-1:0] q_o
);

  logic [W-1:0] entry_q;

  // The entry moves one place along the ring on every shift.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      entry_q <= d_i;
    end
  end

  assign q_o = entry_q;

endmodule

`default_nettype wire

// ===== design/best_fit_coalescing_allocator_core.sv =====
// -----------------------------------------------------------------------------
// Best-fit coalescing allocator core
// Block table held in a ring of cells that rotates past one update point.
// -----------------------------------------------------------------------------
// Usage: a request is taken when start_i is high and busy_o is low. The
// command selects allocate, release or report. Each request yields exactly
// one result, shown for one cycle while done_o is high; the receiver cannot
// hold it off and must take it in that cycle.
// The block table is a ring of POOL_GRANULES cells. Allocate, release and a
// report on a laid-out pool make one full rotation to search (best fit,
// neighbours, largest free), and allocate and release make a second rotation
// to write the changes back. An unknown command, a release that is
// misaligned, below one granule, beyond the pool or on an unlaid pool, and a
// report on an unlaid pool make no rotation and go straight to the result.
// busy_o falls as done_o falls. One request is in flight at a time, so a new
// request is not taken until the result of the last one has been shown.
// Reset clears the controller, the stamp counter and the laid-out flag;
// the table itself is undefined until the first allocate lays it out, so
// no clearing sweep is needed.
// -----------------------------------------------------------------------------
`default_nettype none

module best_fit_coalescing_allocator_core
  import bfca_pkg::*;
#(
  parameter int unsigned POOL_GRANULES = PoolGranulesDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  output logic               busy_o,
  input  wire logic [1:0]    command_i,
  input  wire logic [15:0]   request_bytes_i,
  input  wire logic [13:0]   payload_offset_i,
  output logic               done_o,
  output logic [13:0]        granted_offset_o,
  output logic               granted_o,
  output logic [13:0]        largest_free_bytes_o
);

  localparam int unsigned GW = $clog2(POOL_GRANULES);
  localparam int unsigned IW = $clog2(POOL_GRANULES);
  localparam int unsigned EW = 2 + GW + SW;

  // Ring of cells.
  logic [EW-1:0] ring [POOL_GRANULES];
  logic [EW-1:0] wb;
  logic          shift;

  for (genvar i = 0; i < POOL_GRANULES; i++) begin : g_cell
    if (i == POOL_GRANULES - 1) begin : g_tail
      bfca_cell #(.W(EW)) u_cell (.clk_i(clk_i), .shift_i(shift), .d_i(wb), .q_o(ring[i]));
    end else begin : g_mid
      bfca_cell #(.W(EW)) u_cell (
        .clk_i(clk_i), .shift_i(shift), .d_i(ring[i+1]), .q_o(ring[i])
      );
    end
  end

  // Control and request registers.
  state_e         state_q;
  logic [IW-1:0]  idx_q;
  logic [SW-1:0]  ctr_q;
  logic           ready_q;
  logic [1:0]     cmd_q;
  logic [XW-1:0]  need_q;
  logic           lay_q;
  logic [IW-1:0]  h_q;

  // Search results.
  logic           found_q;
  logic [IW-1:0]  best_q;
  logic [GW-1:0]  bg_q;
  logic [SW-1:0]  bs_q;
  logic [GW-1:0]  max_q;
  logic           hmark_q, hfree_q;
  logic [GW-1:0]  hg_q;
  logic [XW-1:0]  n_q;
  logic           seen_h_q;
  logic           nmark_q, nfree_q;
  logic [GW-1:0]  ng_q;
  logic           pv_valid_q, pv_free_q;
  logic [IW-1:0]  pv_q;
  logic [GW-1:0]  pvg_q;

  // Result registers.
  logic [13:0]    off_res_q, lfb_res_q;
  logic           gr_res_q;

  // Head entry, seen through the pending lay-out.
  logic           e_mark, e_free;
  logic [GW-1:0]  e_gran;
  logic [SW-1:0]  e_stamp;
  logic [XW-1:0]  idx_x;
  logic           last;

  always_comb begin
    idx_x = XW'(idx_q);
    last  = (idx_q == IW'(POOL_GRANULES - 1));
    if (lay_q) begin
      e_mark  = (idx_q == '0);
      e_free  = (idx_q == '0);
      e_gran  = GW'(POOL_GRANULES - 1);
      e_stamp = ctr_q;
    end else begin
      e_mark  = ring[0][EW-1];
      e_free  = ring[0][EW-2];
      e_gran  = ring[0][SW +: GW];
      e_stamp = ring[0][SW-1:0];
    end
  end

  // Derived quantities for the write-back rotation.
  logic           split, ok, merge_n, merge_p;
  logic [GW-1:0]  gh2;
  logic [XW-1:0]  rest;
  always_comb begin
    split   = found_q && (XW'(bg_q) >= need_q + XW'(1));
    rest    = XW'(best_q) + need_q + XW'(1);
    ok      = hmark_q && !hfree_q;
    merge_n = ok && (n_q < XW'(POOL_GRANULES)) && nmark_q && nfree_q;
    merge_p = ok && pv_valid_q && pv_free_q;
    gh2     = merge_n ? GW'(hg_q + ng_q + GW'(1)) : hg_q;
  end

  // Write-back value for the tail cell.
  logic           w_mark, w_free;
  logic [GW-1:0]  w_gran;
  logic [SW-1:0]  w_stamp;
  always_comb begin
    w_mark  = e_mark;
    w_free  = e_free;
    w_gran  = e_gran;
    w_stamp = e_stamp;
    if (state_q == S_APPLY) begin
      if (cmd_q == CMD_ALLOC) begin
        if (found_q && idx_q == best_q) begin
          w_free = 1'b0;
          if (split) w_gran = GW'(need_q);
        end
        if (split && idx_x == rest) begin
          w_mark  = 1'b1;
          w_free  = 1'b1;
          w_gran  = GW'(XW'(bg_q) - need_q - XW'(1));
          w_stamp = ctr_q + SW'(lay_q);
        end
      end else if (cmd_q == CMD_RELEASE && ok) begin
        if (merge_n && idx_x == n_q) begin
          w_mark = 1'b0;
          w_free = 1'b0;
        end
        if (idx_q == h_q) begin
          if (merge_p) begin
            w_mark = 1'b0;
            w_free = 1'b0;
          end else begin
            w_gran  = gh2;
            w_free  = 1'b1;
            w_stamp = ctr_q;
          end
        end
        if (merge_p && idx_q == pv_q) begin
          w_gran  = GW'(pvg_q + gh2 + GW'(1));
          w_free  = 1'b1;
          w_stamp = ctr_q;
        end
      end
    end
    wb    = (state_q == S_APPLY) ? {w_mark, w_free, w_gran, w_stamp} : ring[0];
    shift = (state_q == S_SCAN) || (state_q == S_APPLY);
  end

  // Request decode at acceptance.
  logic           accept;
  logic [16:0]    bytes_up;
  logic [XW-1:0]  hh;
  logic           rel_ok;
  always_comb begin
    accept   = start_i && (state_q == S_IDLE);
    bytes_up = {1'b0, request_bytes_i} + 17'd31;
    hh       = XW'(payload_offset_i >> GranuleShift) - XW'(1);
    rel_ok   = ready_q && (payload_offset_i[GranuleShift-1:0] == '0) &&
               (payload_offset_i >= 14'd32) && (hh < XW'(POOL_GRANULES));
  end

  // Scan candidate for best fit.
  logic cand, better;
  always_comb begin
    cand   = e_mark && e_free && (XW'(e_gran) >= need_q) && (need_q != '0);
    better = !found_q || (e_gran < bg_q) || ((e_gran == bg_q) && (e_stamp < bs_q));
  end

  // Controller.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      ctr_q   <= '0;
      ready_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          idx_q <= '0;
          if (accept) begin
            if (cmd_e'(command_i) == CMD_NONE) begin
              state_q <= S_RESP;
            end else if (cmd_e'(command_i) == CMD_RELEASE) begin
              state_q <= rel_ok ? S_SCAN : S_RESP;
            end else if (cmd_e'(command_i) == CMD_REPORT && !ready_q) begin
              ctr_q   <= ctr_q + SW'(1);
              state_q <= S_RESP;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          idx_q <= last ? '0 : idx_q + IW'(1);
          if (last) begin
            if (cmd_q == CMD_REPORT) begin
              ready_q <= 1'b0;
              state_q <= S_RESP;
            end else begin
              state_q <= S_APPLY;
            end
          end
        end
        S_APPLY: begin
          idx_q <= last ? '0 : idx_q + IW'(1);
          if (last) begin
            state_q <= S_RESP;
            if (cmd_q == CMD_ALLOC) begin
              ready_q <= 1'b1;
              ctr_q   <= ctr_q + SW'(lay_q) + SW'(split);
            end else if (ok) begin
              ctr_q <= ctr_q + SW'(1);
            end
          end
        end
        S_RESP: begin
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Request capture and search tracking.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q      <= command_i;
      need_q     <= XW'(bytes_up >> GranuleShift);
      lay_q      <= !ready_q && (cmd_e'(command_i) == CMD_ALLOC);
      h_q        <= IW'(hh);
      found_q    <= 1'b0;
      max_q      <= '0;
      seen_h_q   <= 1'b0;
      hmark_q    <= 1'b0;
      hfree_q    <= 1'b0;
      nmark_q    <= 1'b0;
      nfree_q    <= 1'b0;
      pv_valid_q <= 1'b0;
      off_res_q  <= '0;
      gr_res_q   <= 1'b0;
      lfb_res_q  <= '0;
      if (cmd_e'(command_i) == CMD_REPORT && !ready_q) begin
        lfb_res_q <= 14'(XW'(POOL_GRANULES - 1) << GranuleShift);
      end
    end else if (state_q == S_SCAN) begin
      // Best fit.
      if (cand && better) begin
        found_q <= 1'b1;
        best_q  <= idx_q;
        bg_q    <= e_gran;
        bs_q    <= e_stamp;
      end
      // Largest free payload.
      if (e_mark && e_free && e_gran > max_q) max_q <= e_gran;
      // Released block, its next neighbour and its previous neighbour.
      if (idx_q == h_q) begin
        seen_h_q <= 1'b1;
        hmark_q  <= e_mark;
        hfree_q  <= e_free;
        hg_q     <= e_gran;
        n_q      <= XW'(idx_q) + XW'(e_gran) + XW'(1);
      end
      if (seen_h_q && idx_x == n_q) begin
        nmark_q <= e_mark;
        nfree_q <= e_free;
        ng_q    <= e_gran;
      end
      if (idx_q < h_q && e_mark) begin
        pv_valid_q <= 1'b1;
        pv_q       <= idx_q;
        pv_free_q  <= e_free;
        pvg_q      <= e_gran;
      end
      if (last) begin
        if (cmd_q == CMD_REPORT) begin
          lfb_res_q <= 14'((XW'(max_q) > XW'(e_mark && e_free ? e_gran : '0) ?
                            XW'(max_q) : XW'(e_mark && e_free ? e_gran : '0))
                           << GranuleShift);
        end else if (cmd_q == CMD_ALLOC && ((cand && better) || found_q)) begin
          gr_res_q  <= 1'b1;
          off_res_q <= 14'((XW'((cand && better) ? idx_q : best_q) + XW'(1))
                           << GranuleShift);
        end
      end
    end
  end

  // Outputs.
  assign busy_o               = (state_q != S_IDLE);
  assign done_o               = (state_q == S_RESP);
  assign granted_offset_o     = off_res_q;
  assign granted_o            = gr_res_q;
  assign largest_free_bytes_o = lfb_res_q;

endmodule

`default_nettype wire

// ===== design/bfca_checker.sv =====
// -----------------------------------------------------------------------------
// Allocator port checker
// Concurrent checks on the request and result ports of the allocator core.
// -----------------------------------------------------------------------------
`default_nettype none

module bfca_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start_i,
  input wire logic        busy_o,
  input wire logic        done_o,
  input wire logic        granted_o,
  input wire logic [13:0] granted_offset_o
);

  // A result strobe lasts one cycle.
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held for more than one cycle");

  // An accepted request makes the core busy.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("request taken without busy");

  // A result is only shown while a request is in flight.
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("result outside a request");

  // A result without a grant reports offset zero; a grant is granule aligned and nonzero.
  a_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((!granted_o && granted_offset_o == 14'd0) ||
                (granted_o && granted_offset_o[4:0] == 5'd0 &&
                 granted_offset_o != 14'd0)))
    else $error("granted offset inconsistent");

endmodule

bind best_fit_coalescing_allocator_core bfca_checker u_bfca_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
  .done_o(done_o), .granted_o(granted_o), .granted_offset_o(granted_offset_o)
);

`default_nettype wire
